@@ rtl/core/gtwh_pkg.sv @@
// Shared widths, types and reset values for the GPIB three-wire handshake engine.
package gtwh_pkg;

   localparam int KindWidth = 2;
   localparam int ByteWidth = 8;
   localparam int WaitWidth = 24;
   localparam int LimitWidth = 16;
   localparam int SettleWidth = 8;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 24;

   typedef logic [KindWidth-1:0] kind_type;
   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [WaitWidth-1:0] wait_type;
   typedef logic [LimitWidth-1:0] limit_type;
   typedef logic [SettleWidth-1:0] settle_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   typedef logic [CsrDataWidth-1:0] csr_data_type;

   localparam kind_type KIND_TICK = 2'd0;
   localparam kind_type KIND_SEND = 2'd1;
   localparam kind_type KIND_RECEIVE = 2'd2;
   localparam kind_type KIND_RELEASE = 2'd3;

   localparam csr_index_type CSR_WAIT_LIMIT = 2'd0;
   localparam csr_index_type CSR_RX_TIMEOUT = 2'd1;
   localparam csr_index_type CSR_SETTLE = 2'd2;

   localparam limit_type WAIT_LIMIT_RESET = 16'd1000;
   localparam wait_type RX_TIMEOUT_RESET = 24'd100;
   localparam settle_type SETTLE_RESET = 8'd1;

   localparam byte_type BUS_RELEASED = 8'hFF;
   localparam wait_type WAIT_MAX = {WaitWidth{1'b1}};

endpackage

@@ rtl/core/gtwh_req_if.sv @@
// Request channel interface: one tick of sampled bus lines plus an optional command.
interface gtwh_req_if;
   import gtwh_pkg::*;

   logic valid;
   logic ready;
   kind_type kind;
   byte_type tx_byte;
   logic atn_level;
   logic eoi_level;
   logic dav_in;
   logic nrfd_in;
   logic ndac_in;
   logic eoi_in;
   byte_type bus_in;

   modport source (
      output valid, kind, tx_byte, atn_level, eoi_level, dav_in, nrfd_in, ndac_in, eoi_in,
             bus_in,
      input ready
   );
   modport sink (
      input valid, kind, tx_byte, atn_level, eoi_level, dav_in, nrfd_in, ndac_in, eoi_in,
            bus_in,
      output ready
   );
endinterface

@@ rtl/core/gtwh_rsp_if.sv @@
// Response channel interface: line drive levels and status after one tick.
interface gtwh_rsp_if;
   import gtwh_pkg::*;

   logic valid;
   logic ready;
   byte_type bus_drive;
   logic dav_drive;
   logic nrfd_drive;
   logic ndac_drive;
   logic atn_drive;
   logic eoi_drive;
   logic busy_res;
   logic done_res;
   logic success;
   byte_type rx_byte;
   logic rx_end;

   modport source (
      output valid, bus_drive, dav_drive, nrfd_drive, ndac_drive, atn_drive, eoi_drive,
             busy_res, done_res, success, rx_byte, rx_end,
      input ready
   );
   modport sink (
      input valid, bus_drive, dav_drive, nrfd_drive, ndac_drive, atn_drive, eoi_drive,
            busy_res, done_res, success, rx_byte, rx_end,
      output ready
   );
endinterface

@@ rtl/core/gtwh_csr_if.sv @@
// Configuration write channel interface: register index and write data.
interface gtwh_csr_if;
   import gtwh_pkg::*;

   logic valid;
   logic ready;
   csr_index_type index;
   csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/gpib_three_wire_handshake_top.sv @@
// Top level of the GPIB three-wire handshake engine, controller side.
//
//   channel   direction   contents
//   req_ch    in          command kind, byte to send, ATN/EOI levels, sampled lines
//   rsp_ch    out         line drive levels, busy, done, success, received byte
//   csr_ch    in          register index and write data
//
// Every request is one tick and yields exactly one response, registered and valid in the cycle after it is accepted.
// A request is taken in every cycle while the response register is empty or being read,
// so the sustained rate is one request per clock, set by the single state register update.
// The handshake state doubles as the response register and holds while the response stalls.
// Reset restores the register defaults and leaves all lines released with the engine idle.
module gpib_three_wire_handshake_top (
   input logic clock,
   input logic reset,
   gtwh_req_if.sink req_ch,
   gtwh_rsp_if.source rsp_ch,
   gtwh_csr_if.sink csr_ch
);
   import gtwh_pkg::*;

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_RFD1 = 3'd1;
   localparam logic [2:0] PH_SETTLE = 3'd2;
   localparam logic [2:0] PH_DAC = 3'd3;
   localparam logic [2:0] PH_RFD2 = 3'd4;
   localparam logic [2:0] PH_RDAV = 3'd5;
   localparam logic [2:0] PH_RDAVH = 3'd6;

   limit_type wait_limit_ff;
   wait_type rx_timeout_ff;
   settle_type settle_ff;

   logic [2:0] phase_ff, phase_in;
   wait_type wait_ff, wait_in;
   byte_type tx_ff, tx_in;
   byte_type rx_ff, rx_in;
   logic rx_end_ff, rx_end_in;
   byte_type bus_ff, bus_in;
   logic dav_ff, dav_in;
   logic nrfd_ff, nrfd_in;
   logic ndac_ff, ndac_in;
   logic atn_ff, atn_in;
   logic eoi_ff, eoi_in;
   logic done_ff, done_in;
   logic ok_ff, ok_in;
   logic rsp_valid_ff;

   logic accept;
   wait_type wait_inc;
   logic limit_hit;
   logic timeout_hit;
   logic settle_hit;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   assign wait_inc = (wait_ff < WAIT_MAX) ? wait_ff + 1'b1 : wait_ff;
   assign limit_hit = wait_inc >= {{(WaitWidth-LimitWidth){1'b0}}, wait_limit_ff};
   assign timeout_hit = wait_inc >= rx_timeout_ff;
   assign settle_hit = wait_inc >= {{(WaitWidth-SettleWidth){1'b0}}, settle_ff};

   always_comb begin
      phase_in = phase_ff;
      wait_in = wait_ff;
      tx_in = tx_ff;
      rx_in = rx_ff;
      rx_end_in = rx_end_ff;
      bus_in = bus_ff;
      dav_in = dav_ff;
      nrfd_in = nrfd_ff;
      ndac_in = ndac_ff;
      atn_in = atn_ff;
      eoi_in = eoi_ff;
      done_in = 1'b0;
      ok_in = 1'b0;
      if (req_ch.kind == KIND_RELEASE) begin
         ok_in = (phase_ff == PH_IDLE);
         done_in = 1'b1;
         bus_in = BUS_RELEASED;
         dav_in = 1'b1;
         nrfd_in = 1'b1;
         ndac_in = 1'b1;
         atn_in = req_ch.atn_level;
         eoi_in = req_ch.eoi_level;
         phase_in = PH_IDLE;
         wait_in = '0;
      end else if (phase_ff == PH_IDLE) begin
         if (req_ch.kind == KIND_SEND) begin
            tx_in = req_ch.tx_byte;
            atn_in = req_ch.atn_level;
            eoi_in = req_ch.eoi_level;
            phase_in = PH_RFD1;
            wait_in = '0;
         end else if (req_ch.kind == KIND_RECEIVE) begin
            atn_in = req_ch.atn_level;
            eoi_in = req_ch.eoi_level;
            ndac_in = 1'b0;
            nrfd_in = 1'b1;
            phase_in = PH_RDAV;
            wait_in = '0;
         end
      end else begin
         unique case (phase_ff)
            PH_RFD1: begin
               if (req_ch.nrfd_in) begin
                  bus_in = ~tx_ff;
                  wait_in = '0;
                  if (settle_ff == '0) begin
                     dav_in = 1'b0;
                     phase_in = PH_DAC;
                  end else begin
                     phase_in = PH_SETTLE;
                  end
               end else begin
                  wait_in = wait_inc;
                  if (limit_hit) begin
                     bus_in = BUS_RELEASED;
                     dav_in = 1'b1;
                     phase_in = PH_IDLE;
                     done_in = 1'b1;
                  end
               end
            end
            PH_SETTLE: begin
               wait_in = wait_inc;
               if (settle_hit) begin
                  dav_in = 1'b0;
                  phase_in = PH_DAC;
                  wait_in = '0;
               end
            end
            PH_DAC: begin
               if (req_ch.ndac_in) begin
                  dav_in = 1'b1;
                  bus_in = BUS_RELEASED;
                  phase_in = PH_RFD2;
                  wait_in = '0;
               end else begin
                  wait_in = wait_inc;
                  if (limit_hit) begin
                     dav_in = 1'b1;
                     bus_in = BUS_RELEASED;
                     phase_in = PH_IDLE;
                     done_in = 1'b1;
                  end
               end
            end
            PH_RFD2: begin
               if (req_ch.nrfd_in) begin
                  phase_in = PH_IDLE;
                  done_in = 1'b1;
                  ok_in = 1'b1;
               end else begin
                  wait_in = wait_inc;
                  if (limit_hit) begin
                     phase_in = PH_IDLE;
                     done_in = 1'b1;
                  end
               end
            end
            PH_RDAV: begin
               if (!req_ch.dav_in) begin
                  nrfd_in = 1'b0;
                  rx_in = ~req_ch.bus_in;
                  rx_end_in = !req_ch.eoi_in;
                  ndac_in = 1'b1;
                  phase_in = PH_RDAVH;
                  wait_in = '0;
               end else begin
                  wait_in = wait_inc;
                  if (timeout_hit) begin
                     ndac_in = 1'b1;
                     nrfd_in = 1'b1;
                     phase_in = PH_IDLE;
                     done_in = 1'b1;
                  end
               end
            end
            PH_RDAVH: begin
               if (!req_ch.dav_in) begin
                  wait_in = wait_inc;
               end
               if (req_ch.dav_in || limit_hit) begin
                  ndac_in = 1'b0;
                  phase_in = PH_IDLE;
                  done_in = 1'b1;
                  ok_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_limit_ff <= WAIT_LIMIT_RESET;
         rx_timeout_ff <= RX_TIMEOUT_RESET;
         settle_ff <= SETTLE_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_WAIT_LIMIT: wait_limit_ff <= csr_ch.data[LimitWidth-1:0];
            CSR_RX_TIMEOUT: rx_timeout_ff <= csr_ch.data[WaitWidth-1:0];
            CSR_SETTLE: settle_ff <= csr_ch.data[SettleWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff <= '0;
         tx_ff <= '0;
         rx_ff <= '0;
         rx_end_ff <= 1'b0;
         bus_ff <= BUS_RELEASED;
         dav_ff <= 1'b1;
         nrfd_ff <= 1'b1;
         ndac_ff <= 1'b1;
         atn_ff <= 1'b1;
         eoi_ff <= 1'b1;
         done_ff <= 1'b0;
         ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            wait_ff <= wait_in;
            tx_ff <= tx_in;
            rx_ff <= rx_in;
            rx_end_ff <= rx_end_in;
            bus_ff <= bus_in;
            dav_ff <= dav_in;
            nrfd_ff <= nrfd_in;
            ndac_ff <= ndac_in;
            atn_ff <= atn_in;
            eoi_ff <= eoi_in;
            done_ff <= done_in;
            ok_ff <= done_in && ok_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.bus_drive = bus_ff;
   assign rsp_ch.dav_drive = dav_ff;
   assign rsp_ch.nrfd_drive = nrfd_ff;
   assign rsp_ch.ndac_drive = ndac_ff;
   assign rsp_ch.atn_drive = atn_ff;
   assign rsp_ch.eoi_drive = eoi_ff;
   assign rsp_ch.busy_res = (phase_ff != PH_IDLE);
   assign rsp_ch.done_res = done_ff;
   assign rsp_ch.success = ok_ff;
   assign rsp_ch.rx_byte = rx_ff;
   assign rsp_ch.rx_end = rx_end_ff;

endmodule

@@ sim/gtwh_handshake_check.sv @@
// Line-state predictor and response comparison for the GPIB three-wire handshake engine.
`timescale 1ns / 100ps

module gtwh_handshake_check (
   input logic clock,
   input logic reset,
   gtwh_req_if req_mon,
   gtwh_rsp_if rsp_mon,
   gtwh_csr_if csr_mon,
   output int failures,
   output int pending
);
   import gtwh_pkg::*;

   typedef enum logic [3:0] {
      HS_IDLE,
      HS_READY_WAIT,
      HS_SETTLE,
      HS_ACCEPT_WAIT,
      HS_READY_AFTER,
      HS_DAV_WAIT,
      HS_DAV_RELEASE
   } hs_phase_type;

   typedef struct packed {
      byte_type bus_drive;
      logic dav_drive;
      logic nrfd_drive;
      logic ndac_drive;
      logic atn_drive;
      logic eoi_drive;
      logic busy_res;
      logic done_res;
      logic success;
      byte_type rx_byte;
      logic rx_end;
   } line_status_type;

   hs_phase_type hs_phase;
   wait_type wait_count;
   byte_type tx_hold;
   byte_type rx_hold;
   logic rx_last;
   byte_type bus_out;
   logic dav_out;
   logic nrfd_out;
   logic ndac_out;
   logic atn_out;
   logic eoi_out;

   limit_type wait_limit;
   wait_type rx_timeout;
   settle_type settle_ticks;

   line_status_type expected_lines[$];

   function automatic bit wait_expired(input int unsigned limit);
      if (wait_count != WAIT_MAX) begin
         wait_count = wait_count + 1'b1;
      end
      return 32'(wait_count) >= limit;
   endfunction

   function automatic line_status_type next_line_state(
      input kind_type kind,
      input byte_type tx,
      input logic atn, eoi, dav, nrfd, ndac, eoi_in,
      input byte_type bus
   );
      line_status_type s;
      logic done;
      logic ok;
      logic finish;
      done = 1'b0;
      ok = 1'b0;
      if (kind == KIND_RELEASE) begin
         ok = (hs_phase == HS_IDLE);
         done = 1'b1;
         bus_out = BUS_RELEASED;
         dav_out = 1'b1;
         nrfd_out = 1'b1;
         ndac_out = 1'b1;
         atn_out = atn;
         eoi_out = eoi;
         hs_phase = HS_IDLE;
         wait_count = '0;
      end else if (hs_phase == HS_IDLE) begin
         if (kind == KIND_SEND) begin
            tx_hold = tx;
            atn_out = atn;
            eoi_out = eoi;
            hs_phase = HS_READY_WAIT;
            wait_count = '0;
         end else if (kind == KIND_RECEIVE) begin
            atn_out = atn;
            eoi_out = eoi;
            ndac_out = 1'b0;
            nrfd_out = 1'b1;
            hs_phase = HS_DAV_WAIT;
            wait_count = '0;
         end
      end else begin
         case (hs_phase)
            HS_READY_WAIT: begin
               if (nrfd) begin
                  bus_out = ~tx_hold;
                  wait_count = '0;
                  if (settle_ticks == 0) begin
                     dav_out = 1'b0;
                     hs_phase = HS_ACCEPT_WAIT;
                  end else begin
                     hs_phase = HS_SETTLE;
                  end
               end else if (wait_expired(32'(wait_limit))) begin
                  bus_out = BUS_RELEASED;
                  dav_out = 1'b1;
                  hs_phase = HS_IDLE;
                  done = 1'b1;
               end
            end
            HS_SETTLE: begin
               if (wait_expired(32'(settle_ticks))) begin
                  dav_out = 1'b0;
                  hs_phase = HS_ACCEPT_WAIT;
                  wait_count = '0;
               end
            end
            HS_ACCEPT_WAIT: begin
               if (ndac) begin
                  dav_out = 1'b1;
                  bus_out = BUS_RELEASED;
                  hs_phase = HS_READY_AFTER;
                  wait_count = '0;
               end else if (wait_expired(32'(wait_limit))) begin
                  dav_out = 1'b1;
                  bus_out = BUS_RELEASED;
                  hs_phase = HS_IDLE;
                  done = 1'b1;
               end
            end
            HS_READY_AFTER: begin
               if (nrfd) begin
                  hs_phase = HS_IDLE;
                  done = 1'b1;
                  ok = 1'b1;
               end else if (wait_expired(32'(wait_limit))) begin
                  hs_phase = HS_IDLE;
                  done = 1'b1;
               end
            end
            HS_DAV_WAIT: begin
               if (!dav) begin
                  nrfd_out = 1'b0;
                  rx_hold = ~bus;
                  rx_last = !eoi_in;
                  ndac_out = 1'b1;
                  hs_phase = HS_DAV_RELEASE;
                  wait_count = '0;
               end else if (wait_expired(32'(rx_timeout))) begin
                  ndac_out = 1'b1;
                  nrfd_out = 1'b1;
                  hs_phase = HS_IDLE;
                  done = 1'b1;
               end
            end
            HS_DAV_RELEASE: begin
               if (dav) begin
                  finish = 1'b1;
               end else begin
                  finish = wait_expired(32'(wait_limit));
               end
               if (finish) begin
                  ndac_out = 1'b0;
                  hs_phase = HS_IDLE;
                  done = 1'b1;
                  ok = 1'b1;
               end
            end
            default: begin
               hs_phase = HS_IDLE;
            end
         endcase
      end
      s.bus_drive = bus_out;
      s.dav_drive = dav_out;
      s.nrfd_drive = nrfd_out;
      s.ndac_drive = ndac_out;
      s.atn_drive = atn_out;
      s.eoi_drive = eoi_out;
      s.busy_res = (hs_phase != HS_IDLE);
      s.done_res = done;
      s.success = done & ok;
      s.rx_byte = rx_hold;
      s.rx_end = rx_last;
      return s;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      line_status_type want;
      if (reset) begin
         wait_limit = WAIT_LIMIT_RESET;
         rx_timeout = RX_TIMEOUT_RESET;
         settle_ticks = SETTLE_RESET;
         hs_phase = HS_IDLE;
         wait_count = '0;
         tx_hold = '0;
         rx_hold = '0;
         rx_last = 1'b0;
         bus_out = BUS_RELEASED;
         dav_out = 1'b1;
         nrfd_out = 1'b1;
         ndac_out = 1'b1;
         atn_out = 1'b1;
         eoi_out = 1'b1;
         expected_lines.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_lines.size() == 0) begin
               $error("response accepted with no request outstanding");
               failures++;
            end else begin
               want = expected_lines.pop_front();
               check_field("bus_drive", want.bus_drive, rsp_mon.bus_drive);
               check_field("dav_drive", 8'(want.dav_drive), 8'(rsp_mon.dav_drive));
               check_field("nrfd_drive", 8'(want.nrfd_drive), 8'(rsp_mon.nrfd_drive));
               check_field("ndac_drive", 8'(want.ndac_drive), 8'(rsp_mon.ndac_drive));
               check_field("atn_drive", 8'(want.atn_drive), 8'(rsp_mon.atn_drive));
               check_field("eoi_drive", 8'(want.eoi_drive), 8'(rsp_mon.eoi_drive));
               check_field("busy_res", 8'(want.busy_res), 8'(rsp_mon.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(rsp_mon.done_res));
               check_field("success", 8'(want.success), 8'(rsp_mon.success));
               check_field("rx_byte", want.rx_byte, rsp_mon.rx_byte);
               check_field("rx_end", 8'(want.rx_end), 8'(rsp_mon.rx_end));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_WAIT_LIMIT: wait_limit = csr_mon.data[LimitWidth-1:0];
               CSR_RX_TIMEOUT: rx_timeout = csr_mon.data;
               CSR_SETTLE: settle_ticks = csr_mon.data[SettleWidth-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_lines.push_back(next_line_state(req_mon.kind, req_mon.tx_byte,
               req_mon.atn_level, req_mon.eoi_level, req_mon.dav_in, req_mon.nrfd_in,
               req_mon.ndac_in, req_mon.eoi_in, req_mon.bus_in));
         end
      end
      pending = expected_lines.size();
   end

endmodule

@@ sim/gpib_three_wire_handshake_top_tb.sv @@
// Testbench top: clock, reset, bus-line request stimulus, stalls and the final verdict.
`timescale 1ns / 100ps

module gpib_three_wire_handshake_top_tb;
   import gtwh_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      kind_type kind;
      byte_type tx_byte;
      logic atn_level;
      logic eoi_level;
      logic dav_in;
      logic nrfd_in;
      logic ndac_in;
      logic eoi_in;
      byte_type bus_in;
   } bus_tick_type;

   logic clock;
   logic reset;
   int failures;
   int pending;
   int issued;
   int cycle_count;
   bit calm;
   int unsigned cur_wait;
   int unsigned cur_rx;
   int unsigned cur_settle;

   gtwh_req_if req_ch ();
   gtwh_rsp_if rsp_ch ();
   gtwh_csr_if csr_ch ();

   gpib_three_wire_handshake_top dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   gtwh_handshake_check line_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_ch),
      .rsp_mon(rsp_ch),
      .csr_mon(csr_ch),
      .failures(failures),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("gpib_three_wire_handshake_top: mismatch");
      $finish;
   end

   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic bus_tick_type line_tick(input kind_type kind, input logic dav, nrfd, ndac);
      bus_tick_type t;
      t.kind = kind;
      t.tx_byte = byte_type'($urandom);
      t.atn_level = 1'($urandom_range(0, 1));
      t.eoi_level = 1'($urandom_range(0, 1));
      t.dav_in = dav;
      t.nrfd_in = nrfd;
      t.ndac_in = ndac;
      t.eoi_in = 1'($urandom_range(0, 1));
      t.bus_in = byte_type'($urandom);
      return t;
   endfunction

   function automatic int span(input int unsigned limit);
      return (limit + 2 > 12) ? 12 : int'(limit + 2);
   endfunction

   task automatic issue(input bus_tick_type t);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= t.kind;
      req_ch.tx_byte <= t.tx_byte;
      req_ch.atn_level <= t.atn_level;
      req_ch.eoi_level <= t.eoi_level;
      req_ch.dav_in <= t.dav_in;
      req_ch.nrfd_in <= t.nrfd_in;
      req_ch.ndac_in <= t.ndac_in;
      req_ch.eoi_in <= t.eoi_in;
      req_ch.bus_in <= t.bus_in;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      issued++;
   endtask

   task automatic put(input kind_type kind, input logic dav, nrfd, ndac);
      issue(line_tick(kind, dav, nrfd, ndac));
   endtask

   task automatic put_byte(input kind_type kind, input logic dav, nrfd, ndac, eoi_in,
                           input byte_type value);
      bus_tick_type t;
      t = line_tick(kind, dav, nrfd, ndac);
      t.eoi_in = eoi_in;
      t.tx_byte = value;
      t.bus_in = value;
      issue(t);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic write_csr(input csr_index_type index, input int unsigned value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= csr_data_type'(value);
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input int unsigned wait_val, rx_val, settle_val);
      drain();
      write_csr(CSR_WAIT_LIMIT, wait_val);
      write_csr(CSR_RX_TIMEOUT, rx_val);
      write_csr(CSR_SETTLE, settle_val);
      csr_ch.valid <= 1'b0;
      cur_wait = wait_val;
      cur_rx = rx_val;
      cur_settle = settle_val;
   endtask

   // The talker script raises NRFD, then NDAC, then NRFD again after random delays.
   task automatic run_send();
      int a;
      int b;
      int c;
      put(KIND_SEND, coin(), coin(), coin());
      a = $urandom_range(0, span(cur_wait));
      repeat (a) put(KIND_TICK, coin(), 1'b0, coin());
      b = cur_settle + $urandom_range(0, span(cur_wait));
      repeat (b + 1) put(KIND_TICK, coin(), 1'b1, 1'b0);
      c = $urandom_range(0, span(cur_wait));
      repeat (c + 1) put(KIND_TICK, coin(), 1'b0, 1'b1);
      repeat (2) put(KIND_TICK, coin(), 1'b1, 1'b1);
   endtask

   // The listener script holds DAV high, then drives a byte with DAV low, then releases it.
   task automatic run_receive();
      int a;
      int b;
      put(KIND_RECEIVE, coin(), coin(), coin());
      a = $urandom_range(0, (cur_rx + 2 > 14) ? 14 : int'(cur_rx + 2));
      repeat (a) put(KIND_TICK, 1'b1, coin(), coin());
      b = $urandom_range(1, span(cur_wait));
      repeat (b) put(KIND_TICK, 1'b0, coin(), coin());
      repeat (2) put(KIND_TICK, 1'b1, coin(), coin());
   endtask

   task automatic run_traffic(input int count);
      int stop;
      int choice;
      stop = issued + count;
      while (issued < stop) begin
         choice = $urandom_range(0, 99);
         if (choice < 38) begin
            run_send();
         end else if (choice < 76) begin
            run_receive();
         end else if (choice < 84) begin
            put(KIND_RELEASE, coin(), coin(), coin());
         end else if (choice < 92) begin
            repeat ($urandom_range(1, 4)) begin
               put(kind_type'($urandom_range(0, 3)), coin(), coin(), coin());
            end
         end else begin
            put(kind_type'($urandom_range(1, 2)), 1'b1, 1'b0, 1'b0);
            repeat ($urandom_range(0, 3)) put(KIND_TICK, 1'b1, 1'b0, 1'b0);
            put(kind_type'($urandom_range(1, 3)), 1'b1, 1'b1, 1'b1);
         end
      end
   endtask

   initial begin
      int unsigned wait_val;
      int unsigned rx_val;
      int unsigned settle_val;
      reset = 1'b1;
      issued = 0;
      calm = 1'b0;
      cur_wait = 32'(WAIT_LIMIT_RESET);
      cur_rx = 32'(RX_TIMEOUT_RESET);
      cur_settle = 32'(SETTLE_RESET);
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_TICK;
      req_ch.tx_byte = '0;
      req_ch.atn_level = 1'b1;
      req_ch.eoi_level = 1'b1;
      req_ch.dav_in = 1'b1;
      req_ch.nrfd_in = 1'b1;
      req_ch.ndac_in = 1'b1;
      req_ch.eoi_in = 1'b1;
      req_ch.bus_in = BUS_RELEASED;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_WAIT_LIMIT;
      csr_ch.data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      put(KIND_RELEASE, 1'b1, 1'b1, 1'b1);
      put_byte(KIND_SEND, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00);
      put(KIND_TICK, 1'b1, 1'b1, 1'b0);
      put(KIND_TICK, 1'b1, 1'b1, 1'b0);
      put(KIND_TICK, 1'b1, 1'b0, 1'b1);
      put(KIND_TICK, 1'b1, 1'b1, 1'b1);
      put_byte(KIND_RECEIVE, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00);
      put_byte(KIND_TICK, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00);
      put(KIND_TICK, 1'b1, 1'b1, 1'b1);
      put_byte(KIND_RECEIVE, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
      put_byte(KIND_SEND, 1'b1, 1'b1, 1'b1, 1'b1, 8'h5A);
      put_byte(KIND_TICK, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);
      put(KIND_TICK, 1'b1, 1'b1, 1'b1);
      put_byte(KIND_SEND, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
      put(KIND_TICK, 1'b1, 1'b0, 1'b0);
      put(KIND_RELEASE, 1'b1, 1'b1, 1'b1);

      configure(1, 1, 0);
      put(KIND_SEND, 1'b1, 1'b0, 1'b0);
      put(KIND_TICK, 1'b1, 1'b0, 1'b0);
      put_byte(KIND_SEND, 1'b1, 1'b1, 1'b1, 1'b1, 8'hA5);
      put(KIND_TICK, 1'b1, 1'b1, 1'b0);
      put(KIND_TICK, 1'b1, 1'b1, 1'b0);
      put(KIND_RECEIVE, 1'b1, 1'b1, 1'b1);
      put(KIND_TICK, 1'b1, 1'b1, 1'b1);
      put(KIND_RECEIVE, 1'b1, 1'b1, 1'b1);
      put(KIND_TICK, 1'b0, 1'b1, 1'b1);
      put(KIND_TICK, 1'b0, 1'b1, 1'b1);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               wait_val = 1;
               rx_val = 1;
               settle_val = 0;
            end
            1: begin
               wait_val = 65535;
               rx_val = 16777215;
               settle_val = 255;
            end
            2: begin
               wait_val = 3;
               rx_val = 5;
               settle_val = 2;
            end
            3: begin
               wait_val = $urandom_range(1, 12);
               rx_val = $urandom_range(1, 16);
               settle_val = $urandom_range(0, 4);
            end
            4: begin
               wait_val = 32'(WAIT_LIMIT_RESET);
               rx_val = 32'(RX_TIMEOUT_RESET);
               settle_val = 32'(SETTLE_RESET);
            end
            default: begin
               wait_val = $urandom_range(2, 20);
               rx_val = $urandom_range(2, 30);
               settle_val = $urandom_range(0, 6);
            end
         endcase
         calm = 1'b0;
         put(KIND_RELEASE, 1'b1, 1'b1, 1'b1);
         configure(wait_val, rx_val, settle_val);
         calm = (p == 2);
         run_traffic(180);
      end
      calm = 1'b0;

      drain();
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("gpib_three_wire_handshake_top: match");
      end else begin
         $display("gpib_three_wire_handshake_top: mismatch");
      end
      $finish;
   end

endmodule
